/* rtl/ppm_pkg.sv */
// shared types and constants for the p6 stream parser
// no dependencies; used by ppm_parse_core and ppm_p6_stream_parser
package ppm_pkg;

  // field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned DIM_W   = 14;
  localparam int unsigned ERR_W   = 3;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned LEFT_W  = 29;
  localparam int unsigned PROD_W  = 2 * DIM_W;

  // most digits allowed in width or height
  localparam int unsigned MAX_DIGITS = 4;

  // saturation limits
  localparam logic [DIM_W-1:0]  ACC_MAX  = {DIM_W{1'b1}};
  localparam logic [LEFT_W-1:0] LEFT_MAX = {LEFT_W{1'b1}};

  // header characters
  localparam logic [BYTE_W-1:0] CH_P     = 8'h50;
  localparam logic [BYTE_W-1:0] CH_6     = 8'h36;
  localparam logic [BYTE_W-1:0] CH_2     = 8'h32;
  localparam logic [BYTE_W-1:0] CH_5     = 8'h35;
  localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
  localparam logic [BYTE_W-1:0] CH_9     = 8'h39;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_NL    = 8'h0a;

  // error codes
  localparam logic [ERR_W-1:0] ERR_NONE        = 3'd0;
  localparam logic [ERR_W-1:0] ERR_MAGIC       = 3'd1;
  localparam logic [ERR_W-1:0] ERR_WIDTH       = 3'd2;
  localparam logic [ERR_W-1:0] ERR_WIDTH_LONG  = 3'd3;
  localparam logic [ERR_W-1:0] ERR_HEIGHT      = 3'd4;
  localparam logic [ERR_W-1:0] ERR_HEIGHT_LONG = 3'd5;
  localparam logic [ERR_W-1:0] ERR_MAXVAL      = 3'd6;

  // parser phase, one-hot
  typedef enum logic [10:0] {
    PH_MAGIC_P = 11'b000_0000_0001,
    PH_MAGIC_6 = 11'b000_0000_0010,
    PH_WIDTH   = 11'b000_0000_0100,
    PH_HEIGHT  = 11'b000_0000_1000,
    PH_MAX_2   = 11'b000_0001_0000,
    PH_MAX_5A  = 11'b000_0010_0000,
    PH_MAX_5B  = 11'b000_0100_0000,
    PH_MAX_NL  = 11'b000_1000_0000,
    PH_DATA    = 11'b001_0000_0000,
    PH_DONE    = 11'b010_0000_0000,
    PH_FAIL    = 11'b100_0000_0000
  } phase_t;

  // input item
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              first;
  } in_item_t;

  // result item
  typedef struct packed {
    logic              pixel_valid;
    logic [BYTE_W-1:0] pixel_byte;
    logic              last_pixel;
    logic              header_done;
    logic [DIM_W-1:0]  image_width;
    logic [DIM_W-1:0]  image_height;
    logic [ERR_W-1:0]  error_code;
  } out_item_t;

endpackage

/* rtl/ppm_parse_core.sv */
// header state machine, size accumulators and data byte counter
// depends on ppm_pkg; instantiated by ppm_p6_stream_parser
module ppm_parse_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  ppm_pkg::in_item_t item,
  output ppm_pkg::out_item_t result
);

  ppm_pkg::phase_t                    phase_r, phase_nxt, cur_phase;
  logic [ppm_pkg::DIM_W-1:0]          width_r, width_nxt, cur_width;
  logic [ppm_pkg::DIM_W-1:0]          height_r, height_nxt, cur_height;
  logic [ppm_pkg::CNT_W-1:0]          cnt_r, cnt_nxt, cur_cnt;
  logic [ppm_pkg::LEFT_W-1:0]         left_r, left_nxt, cur_left;
  logic [ppm_pkg::ERR_W-1:0]          err_r, err_nxt, cur_err;
  logic [ppm_pkg::PROD_W-1:0]         prod_r;
  logic [ppm_pkg::PROD_W+1:0]         prod3;
  logic [ppm_pkg::LEFT_W-1:0]         total;
  logic [ppm_pkg::BYTE_W-1:0]         b;
  logic                               is_digit;
  logic                               cnt_full;
  logic                               done;

  // acc*10 + digit, saturating
  function automatic logic [ppm_pkg::DIM_W-1:0] add_digit(
    input logic [ppm_pkg::DIM_W-1:0] acc,
    input logic [3:0]                dig
  );
    logic [ppm_pkg::DIM_W+3:0] v;
    v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{ppm_pkg::DIM_W{1'b0}}, dig};
    if (v > {4'b0000, ppm_pkg::ACC_MAX}) begin
      return ppm_pkg::ACC_MAX;
    end
    return v[ppm_pkg::DIM_W-1:0];
  endfunction

  // size product, ready well before the maxval newline arrives
  always_ff @(posedge clk) begin
    prod_r <= width_r * height_r;
  end

  // times three, saturated to the counter width
  always_comb begin
    prod3 = {2'b00, prod_r} + {1'b0, prod_r, 1'b0};
    if (prod3 > {1'b0, ppm_pkg::LEFT_MAX}) begin
      total = ppm_pkg::LEFT_MAX;
    end else begin
      total = prod3[ppm_pkg::LEFT_W-1:0];
    end
  end

  // a first byte restarts from the reset state
  always_comb begin
    if (item.first) begin
      cur_phase  = ppm_pkg::PH_MAGIC_P;
      cur_width  = '0;
      cur_height = '0;
      cur_cnt    = '0;
      cur_left   = '0;
      cur_err    = ppm_pkg::ERR_NONE;
    end else begin
      cur_phase  = phase_r;
      cur_width  = width_r;
      cur_height = height_r;
      cur_cnt    = cnt_r;
      cur_left   = left_r;
      cur_err    = err_r;
    end
  end

  assign b        = item.data_byte;
  assign is_digit = (b >= ppm_pkg::CH_0) && (b <= ppm_pkg::CH_9);
  assign cnt_full = cur_cnt >= ppm_pkg::CNT_W'(ppm_pkg::MAX_DIGITS);

  // next state and result for one byte
  always_comb begin
    phase_nxt  = cur_phase;
    width_nxt  = cur_width;
    height_nxt = cur_height;
    cnt_nxt    = cur_cnt;
    left_nxt   = cur_left;
    err_nxt    = cur_err;
    result     = '0;

    case (cur_phase)
      ppm_pkg::PH_MAGIC_P: begin
        if (b == ppm_pkg::CH_P) begin
          phase_nxt = ppm_pkg::PH_MAGIC_6;
        end else begin
          phase_nxt = ppm_pkg::PH_FAIL;
          err_nxt   = ppm_pkg::ERR_MAGIC;
        end
      end
      ppm_pkg::PH_MAGIC_6: begin
        if (b == ppm_pkg::CH_6) begin
          phase_nxt = ppm_pkg::PH_WIDTH;
        end else begin
          phase_nxt = ppm_pkg::PH_FAIL;
          err_nxt   = ppm_pkg::ERR_MAGIC;
        end
      end
      ppm_pkg::PH_WIDTH: begin
        if (is_digit) begin
          if (cnt_full) begin
            phase_nxt = ppm_pkg::PH_FAIL;
            err_nxt   = ppm_pkg::ERR_WIDTH_LONG;
          end else begin
            width_nxt = add_digit(cur_width, b[3:0]);
            cnt_nxt   = cur_cnt + 1'b1;
          end
        end else if (b == ppm_pkg::CH_NL && cur_cnt == '0) begin
          // leading newline before the width, skipped
        end else if (b == ppm_pkg::CH_SPACE && cur_cnt != '0) begin
          cnt_nxt   = '0;
          phase_nxt = ppm_pkg::PH_HEIGHT;
        end else begin
          phase_nxt = ppm_pkg::PH_FAIL;
          err_nxt   = ppm_pkg::ERR_WIDTH;
        end
      end
      ppm_pkg::PH_HEIGHT: begin
        if (is_digit) begin
          if (cnt_full) begin
            phase_nxt = ppm_pkg::PH_FAIL;
            err_nxt   = ppm_pkg::ERR_HEIGHT_LONG;
          end else begin
            height_nxt = add_digit(cur_height, b[3:0]);
            cnt_nxt    = cur_cnt + 1'b1;
          end
        end else if (b == ppm_pkg::CH_NL && cur_cnt != '0) begin
          cnt_nxt   = '0;
          phase_nxt = ppm_pkg::PH_MAX_2;
        end else begin
          phase_nxt = ppm_pkg::PH_FAIL;
          err_nxt   = ppm_pkg::ERR_HEIGHT;
        end
      end
      ppm_pkg::PH_MAX_2: begin
        if (b == ppm_pkg::CH_2) begin
          phase_nxt = ppm_pkg::PH_MAX_5A;
        end else begin
          phase_nxt = ppm_pkg::PH_FAIL;
          err_nxt   = ppm_pkg::ERR_MAXVAL;
        end
      end
      ppm_pkg::PH_MAX_5A: begin
        if (b == ppm_pkg::CH_5) begin
          phase_nxt = ppm_pkg::PH_MAX_5B;
        end else begin
          phase_nxt = ppm_pkg::PH_FAIL;
          err_nxt   = ppm_pkg::ERR_MAXVAL;
        end
      end
      ppm_pkg::PH_MAX_5B: begin
        if (b == ppm_pkg::CH_5) begin
          phase_nxt = ppm_pkg::PH_MAX_NL;
        end else begin
          phase_nxt = ppm_pkg::PH_FAIL;
          err_nxt   = ppm_pkg::ERR_MAXVAL;
        end
      end
      ppm_pkg::PH_MAX_NL: begin
        if (b == ppm_pkg::CH_NL) begin
          left_nxt  = total;
          phase_nxt = (total != '0) ? ppm_pkg::PH_DATA : ppm_pkg::PH_DONE;
        end else begin
          phase_nxt = ppm_pkg::PH_FAIL;
          err_nxt   = ppm_pkg::ERR_MAXVAL;
        end
      end
      ppm_pkg::PH_DATA: begin
        result.pixel_valid = 1'b1;
        result.pixel_byte  = b;
        if (cur_left <= ppm_pkg::LEFT_W'(1)) begin
          result.last_pixel = 1'b1;
          left_nxt          = '0;
          phase_nxt         = ppm_pkg::PH_DONE;
        end else begin
          left_nxt = cur_left - 1'b1;
        end
      end
      default: begin
        // done or failed: byte ignored
      end
    endcase

    done = (phase_nxt == ppm_pkg::PH_DATA) || (phase_nxt == ppm_pkg::PH_DONE);
    result.header_done  = done;
    result.image_width  = done ? width_nxt : '0;
    result.image_height = done ? height_nxt : '0;
    result.error_code   = err_nxt;
  end

  // state registers, updated once per accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= ppm_pkg::PH_MAGIC_P;
      width_r  <= '0;
      height_r <= '0;
      cnt_r    <= '0;
      left_r   <= '0;
      err_r    <= ppm_pkg::ERR_NONE;
    end else if (step) begin
      phase_r  <= phase_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      cnt_r    <= cnt_nxt;
      left_r   <= left_nxt;
      err_r    <= err_nxt;
    end
  end

`ifndef SYNTHESIS
  // an error code is shown only while parsing has stopped
  assert property (@(posedge clk) disable iff (!rst_n)
    (err_r != ppm_pkg::ERR_NONE) |-> (phase_r == ppm_pkg::PH_FAIL))
    else $error("error code set outside the fail phase");

  // data phase always has bytes to count
  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == ppm_pkg::PH_DATA) |-> (left_r != '0))
    else $error("data phase with zero bytes left");

  // digit counter never exceeds the limit
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= ppm_pkg::CNT_W'(ppm_pkg::MAX_DIGITS))
    else $error("digit count beyond limit");
`endif

endmodule

/* rtl/ppm_p6_stream_parser.sv */
// top level of the p6 stream parser: input handshake and result register
// depends on ppm_pkg and ppm_parse_core
//
// Takes one byte of a binary P6 image per item and returns one result item per
// byte, in the cycle after it is accepted. A byte is taken every cycle: the
// parse logic is combinational from the state registers into the result
// register, and in_ready stays high as long as the result register is empty or
// is being emptied in the same cycle. The pixel byte count is formed from a
// registered width*height product that settles while the maxval digits go by.
// A byte with first set restarts the parser and is parsed as the first byte of
// a new file; after an error all bytes are ignored until then.
module ppm_p6_stream_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ppm_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ppm_pkg::out_item_t out_data
);

  logic               step;
  logic               out_valid_r;
  ppm_pkg::out_item_t out_data_r;
  ppm_pkg::out_item_t result;

  assign in_ready = !out_valid_r || out_ready;
  assign step     = in_valid && in_ready;

  ppm_parse_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (in_data),
    .result (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // pixel bytes only come after the header
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.pixel_valid) |-> out_data.header_done)
    else $error("pixel item before header done");

  // last marker only on a pixel item
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.last_pixel) |-> out_data.pixel_valid)
    else $error("last marker without pixel");

  // error and header done never together
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.error_code != ppm_pkg::ERR_NONE) |-> !out_data.header_done)
    else $error("error with header done");

  // every accepted item yields a result next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid)
    else $error("accepted item produced no result");
`endif

endmodule

/* sim/ppm_p6_checker.sv */
// result checker for the p6 stream parser: tracks the header state of every
// accepted byte, predicts its result item and compares it field by field
// depends on ppm_pkg
module ppm_p6_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  ppm_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  ppm_pkg::out_item_t out_data,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // parser state as the byte stream has left it
  ppm_pkg::phase_t                ph;
  logic [ppm_pkg::DIM_W-1:0]      w_acc;
  logic [ppm_pkg::DIM_W-1:0]      h_acc;
  logic [ppm_pkg::CNT_W-1:0]      ndig;
  logic [ppm_pkg::LEFT_W-1:0]     remaining;
  logic [ppm_pkg::ERR_W-1:0]      err_code;

  ppm_pkg::out_item_t expected_q[$];
  int                 results_seen;

  initial begin
    fail_count   = 0;
    pending      = 0;
    results_seen = 0;
  end

  function automatic void restart();
    ph        = ppm_pkg::PH_MAGIC_P;
    w_acc     = '0;
    h_acc     = '0;
    ndig      = '0;
    remaining = '0;
    err_code  = ppm_pkg::ERR_NONE;
  endfunction

  // sticky error, parser stops until the next first byte
  function automatic void fail(logic [ppm_pkg::ERR_W-1:0] code);
    err_code = code;
    ph       = ppm_pkg::PH_FAIL;
  endfunction

  // decimal accumulate, saturating at the top of the size field
  function automatic logic [ppm_pkg::DIM_W-1:0] push_digit(
    logic [ppm_pkg::DIM_W-1:0]  acc,
    logic [ppm_pkg::BYTE_W-1:0] b
  );
    int v;
    v = int'(acc) * 10 + int'(b) - int'(ppm_pkg::CH_0);
    return (v > int'(ppm_pkg::ACC_MAX)) ? ppm_pkg::ACC_MAX : ppm_pkg::DIM_W'(v);
  endfunction

  // one byte in, one result item out
  function automatic ppm_pkg::out_item_t parse_byte(ppm_pkg::in_item_t it);
    logic [ppm_pkg::BYTE_W-1:0] b;
    logic                       digit;
    logic                       done;
    longint                     n;
    ppm_pkg::out_item_t         r;
    b     = it.data_byte;
    digit = (b >= ppm_pkg::CH_0) && (b <= ppm_pkg::CH_9);
    r     = '0;
    if (it.first) restart();
    case (ph)
      ppm_pkg::PH_MAGIC_P: begin
        if (b == ppm_pkg::CH_P) ph = ppm_pkg::PH_MAGIC_6;
        else fail(ppm_pkg::ERR_MAGIC);
      end
      ppm_pkg::PH_MAGIC_6: begin
        if (b == ppm_pkg::CH_6) ph = ppm_pkg::PH_WIDTH;
        else fail(ppm_pkg::ERR_MAGIC);
      end
      ppm_pkg::PH_WIDTH: begin
        if (digit) begin
          if (ndig >= ppm_pkg::CNT_W'(ppm_pkg::MAX_DIGITS)) begin
            fail(ppm_pkg::ERR_WIDTH_LONG);
          end else begin
            w_acc = push_digit(w_acc, b);
            ndig++;
          end
        end else if (b == ppm_pkg::CH_NL && ndig == 0) begin
          // newlines ahead of the width are skipped
        end else if (b == ppm_pkg::CH_SPACE && ndig != 0) begin
          ndig = '0;
          ph   = ppm_pkg::PH_HEIGHT;
        end else begin
          fail(ppm_pkg::ERR_WIDTH);
        end
      end
      ppm_pkg::PH_HEIGHT: begin
        if (digit) begin
          if (ndig >= ppm_pkg::CNT_W'(ppm_pkg::MAX_DIGITS)) begin
            fail(ppm_pkg::ERR_HEIGHT_LONG);
          end else begin
            h_acc = push_digit(h_acc, b);
            ndig++;
          end
        end else if (b == ppm_pkg::CH_NL && ndig != 0) begin
          ndig = '0;
          ph   = ppm_pkg::PH_MAX_2;
        end else begin
          fail(ppm_pkg::ERR_HEIGHT);
        end
      end
      ppm_pkg::PH_MAX_2: begin
        if (b == ppm_pkg::CH_2) ph = ppm_pkg::PH_MAX_5A;
        else fail(ppm_pkg::ERR_MAXVAL);
      end
      ppm_pkg::PH_MAX_5A: begin
        if (b == ppm_pkg::CH_5) ph = ppm_pkg::PH_MAX_5B;
        else fail(ppm_pkg::ERR_MAXVAL);
      end
      ppm_pkg::PH_MAX_5B: begin
        if (b == ppm_pkg::CH_5) ph = ppm_pkg::PH_MAX_NL;
        else fail(ppm_pkg::ERR_MAXVAL);
      end
      ppm_pkg::PH_MAX_NL: begin
        if (b == ppm_pkg::CH_NL) begin
          // data byte count, saturating
          n = longint'(w_acc) * longint'(h_acc) * 3;
          if (n > longint'(ppm_pkg::LEFT_MAX)) n = longint'(ppm_pkg::LEFT_MAX);
          remaining = ppm_pkg::LEFT_W'(n);
          ph = (remaining != 0) ? ppm_pkg::PH_DATA : ppm_pkg::PH_DONE;
        end else begin
          fail(ppm_pkg::ERR_MAXVAL);
        end
      end
      ppm_pkg::PH_DATA: begin
        r.pixel_valid = 1'b1;
        r.pixel_byte  = b;
        if (remaining <= 1) begin
          r.last_pixel = 1'b1;
          remaining    = '0;
          ph           = ppm_pkg::PH_DONE;
        end else begin
          remaining--;
        end
      end
      default: ;
    endcase
    done           = (ph == ppm_pkg::PH_DATA) || (ph == ppm_pkg::PH_DONE);
    r.header_done  = done;
    r.image_width  = done ? w_acc : '0;
    r.image_height = done ? h_acc : '0;
    r.error_code   = err_code;
    return r;
  endfunction

  task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      if (fail_count < 10)
        $display("result %0d: %s expected %0d, got %0d", results_seen, fname, want, got);
      fail_count++;
    end
  endtask

  // compare the oldest expectation first, then log the new item
  always @(posedge clk) begin
    ppm_pkg::out_item_t want;
    if (!rst_n) begin
      restart();
      expected_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          if (fail_count < 10)
            $display("result %0d: unexpected item %h", results_seen, out_data);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("pixel_valid", want.pixel_valid, out_data.pixel_valid);
          check_field("pixel_byte", want.pixel_byte, out_data.pixel_byte);
          check_field("last_pixel", want.last_pixel, out_data.last_pixel);
          check_field("header_done", want.header_done, out_data.header_done);
          check_field("image_width", want.image_width, out_data.image_width);
          check_field("image_height", want.image_height, out_data.image_height);
          check_field("error_code", want.error_code, out_data.error_code);
        end
        results_seen++;
      end
      if (in_valid && in_ready) expected_q.push_back(parse_byte(in_data));
    end
    pending = expected_q.size();
  end

endmodule

/* sim/tb_ppm_p6_stream_parser.sv */
// testbench top for the p6 stream parser: builds p6 byte streams, drives them
// with random idling and gives the verdict
// depends on ppm_pkg, ppm_p6_stream_parser and ppm_p6_checker
module tb_ppm_p6_stream_parser;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET = 1700;
  localparam int CALM_ITEMS  = 150;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;

  // how a generated file breaks its header
  typedef enum int {
    FLAW_NONE,
    FLAW_MAGIC,
    FLAW_WIDTH,
    FLAW_WIDTH_LONG,
    FLAW_HEIGHT,
    FLAW_HEIGHT_LONG,
    FLAW_MAXVAL
  } flaw_t;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  ppm_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  ppm_pkg::out_item_t out_data;
  int                 fail_count;
  int                 pending;

  ppm_pkg::in_item_t  stim_q[$];
  bit                 calm      = 1'b0;
  bit                 hold_req  = 1'b0;
  int                 send_mode = 0;
  int                 quiet     = 0;

  ppm_p6_stream_parser dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  ppm_p6_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // watchdog on cycles where neither channel moves an item
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // receiver: random stall bursts, one long hold-off, none near the end
  initial begin
    int  stall;
    int  mode;
    int  cnt;
    bit  held;
    stall = 0;
    mode  = 0;
    cnt   = 0;
    held  = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      cnt++;
      if (cnt % 64 == 0) mode = $urandom_range(0, 2);
      if (hold_req && !held) begin
        held  = 1'b1;
        stall = HOLD_CYCLES;
      end else if (stall == 0 && !calm && mode != 0 &&
                   $urandom_range(0, (mode == 1) ? 9 : 2) == 0) begin
        stall = $urandom_range(1, 19);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic void push(logic [ppm_pkg::BYTE_W-1:0] b, logic f);
    stim_q.push_back('{data_byte: b, first: f});
  endfunction

  function automatic logic [ppm_pkg::BYTE_W-1:0] other_byte(logic [ppm_pkg::BYTE_W-1:0] x);
    logic [ppm_pkg::BYTE_W-1:0] b;
    do b = ppm_pkg::BYTE_W'($urandom_range(0, 255)); while (b == x);
    return b;
  endfunction

  function automatic logic [ppm_pkg::BYTE_W-1:0] non_digit(
    logic [ppm_pkg::BYTE_W-1:0] avoid
  );
    logic [ppm_pkg::BYTE_W-1:0] b;
    do b = ppm_pkg::BYTE_W'($urandom_range(0, 255));
    while ((b >= ppm_pkg::CH_0 && b <= ppm_pkg::CH_9) || b == avoid);
    return b;
  endfunction

  function automatic logic [ppm_pkg::BYTE_W-1:0] rand_digit();
    return ppm_pkg::CH_0 + ppm_pkg::BYTE_W'($urandom_range(0, 9));
  endfunction

  // bytes after a file or after an error, ignored unless the file is still short of data bytes
  function automatic void add_junk();
    repeat ($urandom_range(0, 2)) push(ppm_pkg::BYTE_W'($urandom_range(0, 255)), 1'b0);
  endfunction

  // decimal digits with occasional leading zeros
  function automatic void add_number(int val);
    string s;
    s = $sformatf("%0d", val);
    while (s.len() < ppm_pkg::MAX_DIGITS && $urandom_range(0, 3) == 0) s = {"0", s};
    foreach (s[i]) push(s[i], 1'b0);
  endfunction

  // one file: header with an optional flaw, then ndata data bytes if it has no flaw
  function automatic void add_file(int wd, int ht, int nl, flaw_t flaw, int ndata);
    logic [ppm_pkg::BYTE_W-1:0] maxval[4];
    int                         k;
    int                         pos;
    maxval = '{ppm_pkg::CH_2, ppm_pkg::CH_5, ppm_pkg::CH_5, ppm_pkg::CH_NL};
    if (flaw == FLAW_MAGIC) begin
      if ($urandom_range(0, 1) == 0) begin
        push(other_byte(ppm_pkg::CH_P), 1'b1);
      end else begin
        push(ppm_pkg::CH_P, 1'b1);
        push(other_byte(ppm_pkg::CH_6), 1'b0);
      end
      add_junk();
      return;
    end
    push(ppm_pkg::CH_P, 1'b1);
    push(ppm_pkg::CH_6, 1'b0);
    repeat (nl) push(ppm_pkg::CH_NL, 1'b0);
    // width field
    if (flaw == FLAW_WIDTH || flaw == FLAW_WIDTH_LONG) begin
      k = (flaw == FLAW_WIDTH) ? $urandom_range(0, ppm_pkg::MAX_DIGITS - 1)
                               : ppm_pkg::MAX_DIGITS + $urandom_range(1, 3);
      repeat (k) push(rand_digit(), 1'b0);
      if (flaw == FLAW_WIDTH) begin
        if (k == 0)
          push($urandom_range(0, 1) ? ppm_pkg::CH_SPACE : non_digit(ppm_pkg::CH_NL), 1'b0);
        else push(non_digit(ppm_pkg::CH_SPACE), 1'b0);
      end
      add_junk();
      return;
    end
    add_number(wd);
    push(ppm_pkg::CH_SPACE, 1'b0);
    // height field
    if (flaw == FLAW_HEIGHT || flaw == FLAW_HEIGHT_LONG) begin
      k = (flaw == FLAW_HEIGHT) ? $urandom_range(0, ppm_pkg::MAX_DIGITS - 1)
                                : ppm_pkg::MAX_DIGITS + $urandom_range(1, 3);
      repeat (k) push(rand_digit(), 1'b0);
      if (flaw == FLAW_HEIGHT) begin
        if (k == 0)
          push($urandom_range(0, 1) ? ppm_pkg::CH_NL : non_digit(ppm_pkg::CH_SPACE), 1'b0);
        else push(non_digit(ppm_pkg::CH_NL), 1'b0);
      end
      add_junk();
      return;
    end
    add_number(ht);
    push(ppm_pkg::CH_NL, 1'b0);
    // maxval line
    pos = (flaw == FLAW_MAXVAL) ? $urandom_range(0, 3) : 4;
    for (int i = 0; i < 4; i++) push((i == pos) ? other_byte(maxval[i]) : maxval[i], 1'b0);
    if (flaw == FLAW_MAXVAL) begin
      add_junk();
      return;
    end
    repeat (ndata) push(ppm_pkg::BYTE_W'($urandom_range(0, 255)), 1'b0);
    add_junk();
  endfunction

  // offer one item, with a random idle burst ahead of it
  task automatic send_item(ppm_pkg::in_item_t it);
    int gap;
    if (!calm && send_mode != 0 && $urandom_range(0, (send_mode == 1) ? 9 : 2) == 0) begin
      gap = $urandom_range(1, 19);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin
    int    wd;
    int    ht;
    int    ndata;
    int    nl;
    flaw_t flaw;

    // 1x1 image after a leading newline, then an ignored byte
    push(ppm_pkg::CH_P, 1'b1);
    push(ppm_pkg::CH_6, 1'b0);
    push(ppm_pkg::CH_NL, 1'b0);
    push(ppm_pkg::CH_0 + 8'd1, 1'b0);
    push(ppm_pkg::CH_SPACE, 1'b0);
    push(ppm_pkg::CH_0 + 8'd1, 1'b0);
    push(ppm_pkg::CH_NL, 1'b0);
    push(ppm_pkg::CH_2, 1'b0);
    push(ppm_pkg::CH_5, 1'b0);
    push(ppm_pkg::CH_5, 1'b0);
    push(ppm_pkg::CH_NL, 1'b0);
    push(8'h00, 1'b0);
    push(8'hff, 1'b0);
    push(8'h5a, 1'b0);
    push(8'ha5, 1'b0);
    // empty width, then a byte ignored after the error
    push(ppm_pkg::CH_P, 1'b1);
    push(ppm_pkg::CH_6, 1'b0);
    push(ppm_pkg::CH_SPACE, 1'b0);
    push(ppm_pkg::CH_P, 1'b0);
    // restart on a bad magic byte
    push(8'h51, 1'b1);

    // random files, mostly well formed and small
    while (stim_q.size() < ITEM_TARGET) begin
      flaw = ($urandom_range(0, 9) < 6) ? FLAW_NONE : flaw_t'($urandom_range(1, 6));
      if ($urandom_range(0, 9) == 0) begin
        wd    = $urandom_range(0, 1) ? 9999 : $urandom_range(0, 9999);
        ht    = $urandom_range(0, 1) ? 9999 : $urandom_range(0, 9999);
        ndata = $urandom_range(0, 6);
      end else begin
        wd    = $urandom_range(0, 5);
        ht    = $urandom_range(0, 5);
        ndata = wd * ht * 3;
        if ($urandom_range(0, 6) == 0) ndata = $urandom_range(0, ndata);
      end
      nl = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      add_file(wd, ht, nl, flaw, ndata);
      // stray bytes, some of them restarting the parser
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 6))
          push(ppm_pkg::BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < stim_q.size(); i++) begin
      if (i == stim_q.size() / 3) hold_req = 1'b1;
      if (i >= stim_q.size() - CALM_ITEMS) calm = 1'b1;
      if (i % 50 == 0) send_mode = $urandom_range(0, 2);
      send_item(stim_q[i]);
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* ppm_p6_stream_parser.f */
rtl/ppm_pkg.sv
rtl/ppm_parse_core.sv
rtl/ppm_p6_stream_parser.sv
sim/ppm_p6_checker.sv
sim/tb_ppm_p6_stream_parser.sv
